// ===== src/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int DataWidth = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cau_cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } cau_status_e;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic signed [DataWidth-1:0] a_re;
    logic signed [DataWidth-1:0] a_im;
    logic signed [DataWidth-1:0] b_re;
    logic signed [DataWidth-1:0] b_im;
  } cau_req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_re;
    logic signed [DataWidth-1:0] res_im;
    logic [1:0]                  status;
  } cau_rsp_t;

  // queue entry: request plus front-end classification
  typedef struct packed {
    cau_req_t req;
    logic     is_div;
    logic     div0;
  } cau_entry_t;

endpackage

// ===== src/cau_front.sv =====
// Front end: classifies requests and queues them for the back end.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  cau_req_t   req_i,
  output logic       busy_o,
  input  logic       pop_i,
  output logic       valid_o,
  output cau_entry_t entry_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cau_entry_t          mem_q [DEPTH];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;
  cau_entry_t          ent;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign busy_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push    = start_i && !busy_o;
  assign pop     = pop_i && valid_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    ent.req    = req_i;
    ent.is_div = (req_i.cmd == CMD_DIV);
    ent.div0   = (req_i.b_re == '0) && (req_i.b_im == '0);
    wr_d  = push ? inc(wr_q) : wr_q;
    rd_d  = pop ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/cau_div.sv =====
// Two-lane restoring divider, one quotient bit per lane per cycle.
// Depends on cau_pkg.
module cau_div import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [2*DataWidth:0] num_re_i,
  input  logic signed [2*DataWidth:0] num_im_i,
  input  logic [2*DataWidth-1:0]      den_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic signed [DataWidth-1:0] re_o,
  output logic signed [DataWidth-1:0] im_o,
  output logic                        sat_o
);

  localparam int W    = DataWidth;
  localparam int NB   = 2 * W + FRAC_BITS;
  localparam int CntW = $clog2(NB + 1);

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [2*W-1:0]      den_q;
  logic [2*W-1:0]      rem_q [2];
  logic [NB-1:0]       dvd_q [2];
  logic [NB-1:0]       quo_q [2];
  logic                neg_q [2];
  logic signed [W-1:0] res [2];
  logic                sat [2];

  localparam logic [NB-1:0] MagMax = {{(NB - W + 1){1'b0}}, {(W - 1){1'b1}}};

  function automatic logic [2*W-1:0] mag(input logic signed [2*W:0] v);
    logic [2*W:0] t;
    t = v[2*W] ? -v : v;
    mag = t[2*W-1:0];
  endfunction

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sat[l] = 1'b0;
      res[l] = neg_q[l] ? -quo_q[l][W-1:0] : quo_q[l][W-1:0];
      if (!neg_q[l] && quo_q[l] > MagMax) begin
        sat[l] = 1'b1;
        res[l] = {1'b0, {(W - 1){1'b1}}};
      end else if (neg_q[l] && quo_q[l] > MagMax + NB'(1)) begin
        sat[l] = 1'b1;
        res[l] = {1'b1, {(W - 1){1'b0}}};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign re_o   = res[0];
  assign im_o   = res[1];
  assign sat_o  = sat[0] | sat[1];

  always_ff @(posedge clk_i) begin
    logic [2*W:0] trial;
    if (start_i) begin
      den_q    <= den_i;
      neg_q[0] <= num_re_i[2*W];
      neg_q[1] <= num_im_i[2*W];
      dvd_q[0] <= {mag(num_re_i), {FRAC_BITS{1'b0}}};
      dvd_q[1] <= {mag(num_im_i), {FRAC_BITS{1'b0}}};
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= '0;
        quo_q[l] <= '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        trial = {rem_q[l], dvd_q[l][NB-1]};
        if (trial >= {1'b0, den_q}) begin
          trial = trial - {1'b0, den_q};
          quo_q[l] <= {quo_q[l][NB-2:0], 1'b1};
        end else begin
          quo_q[l] <= {quo_q[l][NB-2:0], 1'b0};
        end
        rem_q[l] <= trial[2*W-1:0];
        dvd_q[l] <= {dvd_q[l][NB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/cau_back.sv =====
// Back end: product stage, combine/saturate stage, divider hookup, result register.
// Depends on cau_pkg and cau_div.
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cau_entry_t entry_i,
  output logic       pop_o,
  output logic       div_busy_o,
  output logic       valid_o,
  output cau_rsp_t   rsp_o
);

  localparam int W = DataWidth;

  logic                  p_vld_q, p_div_q, p_div0_q;
  logic [1:0]            p_cmd_q;
  logic signed [2*W-1:0] p0_q, p1_q, p2_q, p3_q, s0_q, s1_q;
  logic signed [W:0]     sum_re_q, sum_im_q;
  logic                  div_start, div_busy, div_done, div_sat;
  logic signed [W-1:0]   div_re, div_im;
  logic signed [2*W:0]   num_re, num_im, x_re, x_im;
  logic [2*W-1:0]        den;
  logic                  vld_q;
  cau_rsp_t              rsp_q, rsp_d;
  logic                  vld_d;

  // sign-extended (2W+1)-bit value to W bits, sat flag on top
  function automatic logic [W:0] sat_w(input logic signed [2*W:0] x);
    if (x[2*W:W-1] == '0 || x[2*W:W-1] == '1) begin
      sat_w = {1'b0, x[W-1:0]};
    end else if (x[2*W]) begin
      sat_w = {1'b1, 1'b1, {(W - 1){1'b0}}};
    end else begin
      sat_w = {1'b1, 1'b0, {(W - 1){1'b1}}};
    end
  endfunction

  // hold the queue while a divide is in flight so results stay in order
  assign pop_o     = q_valid_i && !div_busy && !(p_vld_q && p_div_q && !p_div0_q);
  assign div_start = p_vld_q && p_div_q && !p_div0_q;
  assign div_busy_o = div_busy;

  assign num_re = (2*W+1)'(p0_q) + (2*W+1)'(p1_q);
  assign num_im = (2*W+1)'(p3_q) - (2*W+1)'(p2_q);
  assign den    = s0_q + s1_q;

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_re_i(num_re),
    .num_im_i(num_im),
    .den_i   (den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .re_o    (div_re),
    .im_o    (div_im),
    .sat_o   (div_sat)
  );

  always_comb begin
    logic [W:0] r, i;
    x_re = (2*W+1)'(sum_re_q);
    x_im = (2*W+1)'(sum_im_q);
    if (p_cmd_q == CMD_MUL) begin
      x_re = ((2*W+1)'(p0_q) - (2*W+1)'(p1_q)) >>> FRAC_BITS;
      x_im = ((2*W+1)'(p2_q) + (2*W+1)'(p3_q)) >>> FRAC_BITS;
    end
    r = sat_w(x_re);
    i = sat_w(x_im);
    vld_d = 1'b0;
    rsp_d = rsp_q;
    if (div_done) begin
      vld_d        = 1'b1;
      rsp_d.res_re = div_re;
      rsp_d.res_im = div_im;
      rsp_d.status = div_sat ? ST_SAT : ST_OK;
    end else if (p_vld_q && p_div_q) begin
      if (p_div0_q) begin
        vld_d        = 1'b1;
        rsp_d.res_re = '0;
        rsp_d.res_im = '0;
        rsp_d.status = ST_DIV0;
      end
    end else if (p_vld_q) begin
      vld_d        = 1'b1;
      rsp_d.res_re = r[W-1:0];
      rsp_d.res_im = i[W-1:0];
      rsp_d.status = (r[W] | i[W]) ? ST_SAT : ST_OK;
    end
  end

  assign valid_o = vld_q;
  assign rsp_o   = rsp_q;

  always_ff @(posedge clk_i) begin
    cau_req_t q;
    q = entry_i.req;
    if (pop_o) begin
      p_cmd_q  <= q.cmd;
      p_div_q  <= entry_i.is_div;
      p_div0_q <= entry_i.div0;
      p0_q     <= q.a_re * q.b_re;
      p1_q     <= q.a_im * q.b_im;
      p2_q     <= q.a_re * q.b_im;
      p3_q     <= q.a_im * q.b_re;
      s0_q     <= q.b_re * q.b_re;
      s1_q     <= q.b_im * q.b_im;
      if (q.cmd == CMD_SUB) begin
        sum_re_q <= (W+1)'(q.a_re) - (W+1)'(q.b_re);
        sum_im_q <= (W+1)'(q.a_im) - (W+1)'(q.b_im);
      end else begin
        sum_re_q <= (W+1)'(q.a_re) + (W+1)'(q.b_re);
        sum_im_q <= (W+1)'(q.a_im) + (W+1)'(q.b_im);
      end
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      p_vld_q <= pop_o;
      vld_q   <= vld_d;
    end
  end

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Complex ALU top level: add, subtract, multiply, divide in signed fixed point.
// Depends on cau_pkg, cau_front, cau_back (which holds cau_div).
//
//  channel   | signals                  | handshake
//  ----------+--------------------------+--------------------------------
//  request   | start_i, req_i, busy_o   | beat taken when start_i && !busy_o
//  result    | valid_o, rsp_o           | one-cycle strobe, no back-pressure
//
// Add, subtract and multiply: one beat per cycle while no divide holds the
// queue; each passes the queue, the product register and the result register.
// Divide: runs in the shared two-lane restoring divider; later beats wait in
// the queue, so results leave in request order.
// Reset clears the queue pointers and all valid flags; no clearing pass.
// busy_o rises only while the request queue is full.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  cau_req_t req_i,
  output logic     busy_o,
  output logic     valid_o,
  output cau_rsp_t rsp_o
);

  logic       q_valid, pop, div_busy;
  cau_entry_t entry;

  cau_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(entry)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .entry_i   (entry),
    .pop_o     (pop),
    .div_busy_o(div_busy),
    .valid_o   (valid_o),
    .rsp_o     (rsp_o)
  );

  // divide by zero always returns zeros
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.status == ST_DIV0 |-> rsp_o.res_re == '0 && rsp_o.res_im == '0)
    else $error("div0 result not zero");

  // nothing leaves the queue while a divide runs
  a_no_pop_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !pop)
    else $error("pop during divide");

  // a running divide blocks all other results until it finishes
  a_div_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy && $past(div_busy) |-> !valid_o)
    else $error("result overtook divide");

endmodule
